// ===== rtl/core/kwmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kwmc_pkg
// Shared types, constants and helpers for the keyword word match counter.
// ----------------------------------------------------------------------------
package kwmc_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned KEY_CHARS  = 16;
    localparam int unsigned KEY_IDX_W  = 4;

    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_LOW_S  = 8'h73;
    localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_BIT    = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_KEY_LEN  = 2'd2,
        REG_NONE     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic advance;
        logic flush;
    } t_cell_ctrl;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/kwmc_cell.sv =====
// ----------------------------------------------------------------------------
// kwmc_cell
// One window position: holds a character, compares the incoming one with
// its keyword character and hands its character on to the next cell.
// ----------------------------------------------------------------------------
module kwmc_cell
    import kwmc_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [CHAR_W-1:0] i_key_char,
    input  logic              i_enable,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_hit,
    output logic              o_is_space
);

    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;

    always_comb begin
        n_char = r_char;
        if (i_ctrl.advance) begin
            n_char = i_ctrl.flush ? '0 : i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char     = r_char;
    assign o_hit      = !i_enable || (fold_case(i_char) == fold_case(i_key_char));
    assign o_is_space = (i_char == CHAR_SPACE);

endmodule

// ===== rtl/core/keyword_word_match_counter.sv =====
// ----------------------------------------------------------------------------
// keyword_word_match_counter
// Counts case-insensitive whole-word keyword occurrences in a text record.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle unless stalled; a record's count is given in
// the cycle after its end-of-record byte. The characters move through a row
// of MAX_KEYWORD_LEN + 1 cells, each comparing its character with one keyword
// character, so the match of every new byte is settled in the cycle it is
// taken. An occurrence counts when preceded by a space and followed by a
// space, comma, period or lower-case s; the start of a record is not a space
// and the end of a record is no follower. A new byte is taken while a count
// still waits to be taken, unless the output is stalled.
module keyword_word_match_counter
    import kwmc_pkg::*;
#(
    parameter int unsigned MAX_KEYWORD_LEN = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CHAR_W-1:0]     i_text_char,
    input  logic                  i_end_of_record,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COUNT_W-1:0]    o_match_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned NCELL  = MAX_KEYWORD_LEN + 1;
    localparam int unsigned FILL_W = $clog2(NCELL + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(NCELL);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_KEYWORD_LEN);

    logic [CFG_DATA_W-1:0] r_key_low;
    logic [CFG_DATA_W-1:0] r_key_high;
    logic [LEN_W-1:0]      r_key_len;

    logic [FILL_W-1:0]  r_fill,    n_fill;
    logic [LEN_W-1:0]   r_skip,    n_skip;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic               r_pend,    n_pend;
    logic               r_pre_ok,  n_pre_ok;
    logic               r_out_vld;
    logic [COUNT_W-1:0] r_out_cnt;

    logic                     accept;
    logic [LEN_W-1:0]         len_eff;
    logic [2*CFG_DATA_W-1:0]  key_all;
    t_cell_ctrl               cell_ctrl;
    logic [CHAR_W-1:0]        cell_in   [NCELL];
    logic [CHAR_W-1:0]        cell_out  [NCELL];
    logic [CHAR_W-1:0]        cell_key  [NCELL];
    logic [NCELL-1:0]         cell_en;
    logic [NCELL-1:0]         cell_hit;
    logic [NCELL-1:0]         cell_space;
    logic                     pre_space;
    logic                     follower;
    logic                     hit;
    logic [COUNT_W-1:0]       count_now;

    assign o_stall = r_out_vld && i_stall;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LEN:  r_key_len  <= i_cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        len_eff = r_key_len;
        if (r_key_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_key_len > LEN_MAX) begin
            len_eff = LEN_MAX;
        end
    end

    assign key_all         = {r_key_high, r_key_low};
    assign cell_ctrl.advance = accept;
    assign cell_ctrl.flush   = i_end_of_record;

    genvar k;
    generate
        for (k = 0; k < NCELL; k++) begin : g_cell
            logic [LEN_W-1:0] key_pos;

            assign key_pos    = len_eff - LEN_W'(k + 1);
            assign cell_en[k] = (LEN_W'(k) < len_eff);
            assign cell_key[k] = key_all[key_pos[KEY_IDX_W-1:0]*CHAR_W +: CHAR_W];

            if (k == 0) begin : g_head
                assign cell_in[k] = i_text_char;
            end else begin : g_link
                assign cell_in[k] = cell_out[k-1];
            end

            kwmc_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (cell_ctrl),
                .i_char     (cell_in[k]),
                .i_key_char (cell_key[k]),
                .i_enable   (cell_en[k]),
                .o_char     (cell_out[k]),
                .o_hit      (cell_hit[k]),
                .o_is_space (cell_space[k])
            );
        end
    endgenerate

    always_comb begin
        pre_space = 1'b0;
        for (int j = 0; j < NCELL; j++) begin
            if (len_eff == LEN_W'(j)) begin
                pre_space = cell_space[j];
            end
        end
    end

    assign hit      = &cell_hit;
    assign follower = (i_text_char == CHAR_SPACE) || (i_text_char == CHAR_COMMA) ||
                      (i_text_char == CHAR_PERIOD) || (i_text_char == CHAR_LOW_S);
    assign count_now = r_count + COUNT_W'(r_pend && r_pre_ok && follower);

    always_comb begin
        n_fill   = r_fill;
        n_skip   = r_skip;
        n_count  = r_count;
        n_pend   = r_pend;
        n_pre_ok = r_pre_ok;
        if (accept) begin
            n_count  = count_now;
            n_pend   = 1'b0;
            n_fill   = (r_fill < FILL_MAX) ? r_fill + FILL_W'(1) : r_fill;
            if (r_skip != '0) begin
                n_skip = r_skip - LEN_W'(1);
            end else if ((LEN_W + 1)'(n_fill) >= (LEN_W + 1)'(len_eff) && hit) begin
                n_pend   = 1'b1;
                n_pre_ok = ((LEN_W + 1)'(n_fill) > (LEN_W + 1)'(len_eff)) && pre_space;
                n_skip   = len_eff;
            end
            if (i_end_of_record) begin
                n_fill   = '0;
                n_skip   = '0;
                n_count  = '0;
                n_pend   = 1'b0;
                n_pre_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_skip   <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_pre_ok <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_skip   <= n_skip;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_pre_ok <= n_pre_ok;
        end
    end

    // result register: one count per record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept && i_end_of_record) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_end_of_record) begin
            r_out_cnt <= count_now;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_match_count = r_out_cnt;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword word match counter.
// ----------------------------------------------------------------------------
// Streams text records into the block and checks every count it returns.
// A scoreboard class keeps its own model of the keyword window and predicts
// the count of each record. A short directed part covers record start and
// end, folding of case, the plural follower and the zero byte. Randomised
// phases then load a new keyword each and send records made mostly of
// keyword occurrences with assorted neighbours, mixed with near misses,
// plain words and noise. Both sides idle at random; one phase holds the
// output off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
    import kwmc_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1250;
    localparam int unsigned MIN_RECORDS    = 40;
    localparam int unsigned PHASE_ITEMS    = 120;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam logic [CHAR_W-1:0] LOW_A    = 8'h61;
    localparam logic [CHAR_W-1:0] LOW_Z    = 8'h7A;

    class match_scoreboard;
        logic [CFG_DATA_W-1:0] key_low;
        logic [CFG_DATA_W-1:0] key_high;
        logic [LEN_W-1:0]      key_len;
        logic [CHAR_W-1:0]     window [0:KEY_CHARS+1];
        int unsigned           fill;
        int unsigned           skip;
        logic [COUNT_W-1:0]    count;
        bit                    waiting;
        bit                    pre_space;
        logic [COUNT_W-1:0]    expected_counts [$];
        int unsigned           chars;
        int unsigned           records;
        int unsigned           found;
        int unsigned           errors;

        function new();
            key_low  = '0;
            key_high = '0;
            key_len  = 5'd1;
            chars    = 0;
            records  = 0;
            found    = 0;
            errors   = 0;
            clear_record();
        endfunction

        function void clear_record();
            for (int k = 0; k <= KEY_CHARS + 1; k++) begin
                window[k] = '0;
            end
            fill      = 0;
            skip      = 0;
            count     = '0;
            waiting   = 1'b0;
            pre_space = 1'b0;
        endfunction

        function void write_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_KEY_LOW: begin
                    key_low = d;
                end
                REG_KEY_HIGH: begin
                    key_high = d;
                end
                REG_KEY_LEN: begin
                    key_len = d[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned eff_len();
            if (key_len == 0) begin
                return 1;
            end
            if (key_len > KEY_CHARS) begin
                return KEY_CHARS;
            end
            return key_len;
        endfunction

        function logic [CHAR_W-1:0] key_char(int unsigned k);
            logic [2*CFG_DATA_W-1:0] both;
            both = {key_high, key_low} >> (8 * (k % KEY_CHARS));
            return both[CHAR_W-1:0];
        endfunction

        function logic [CHAR_W-1:0] lower(logic [CHAR_W-1:0] c);
            if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
                return c + 8'd32;
            end
            return c;
        endfunction

        function void note_transfer(logic [CHAR_W-1:0] c, logic is_last);
            int unsigned len;
            bit          hit;
            len = eff_len();
            chars++;
            if (waiting) begin
                if (pre_space && (c == CHAR_SPACE || c == CHAR_COMMA ||
                                  c == CHAR_PERIOD || c == CHAR_LOW_S)) begin
                    count++;
                    found++;
                end
                waiting = 1'b0;
            end
            for (int k = KEY_CHARS + 1; k > 0; k--) begin
                window[k] = window[k-1];
            end
            window[0] = c;
            if (fill < KEY_CHARS + 1) begin
                fill++;
            end
            if (skip > 0) begin
                skip--;
            end else if (fill >= len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++) begin
                    if (lower(window[k]) != lower(key_char(len - 1 - k))) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    waiting   = 1'b1;
                    pre_space = (fill > len) && (window[len] == CHAR_SPACE);
                    skip      = len;
                end
            end
            if (is_last) begin
                expected_counts.push_back(count);
                records++;
                clear_record();
            end
        endfunction

        function void check_count(logic [COUNT_W-1:0] actual);
            logic [COUNT_W-1:0] want;
            if (expected_counts.size() == 0) begin
                $error("match_count transfer with no record outstanding, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_counts.pop_front();
            if (actual !== want) begin
                $error("match_count expected %0d actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [CHAR_W-1:0]     in_char     = '0;
    logic                  in_eor      = 1'b0;
    logic                  out_stall   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [COUNT_W-1:0]    o_match_count;

    match_scoreboard       sb;
    bit                    sender_calm   = 1'b0;
    bit                    receiver_calm = 1'b0;
    bit                    hold_request  = 1'b0;
    int unsigned           random_items  = 0;
    int unsigned           phase_items   = 0;
    int unsigned           settings      = 0;
    int unsigned           idle_cycles   = 0;
    logic [CHAR_W-1:0]     rec_bytes [$];

    keyword_word_match_counter i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (o_stall),
        .i_text_char     (in_char),
        .i_end_of_record (in_eor),
        .o_valid         (o_valid),
        .i_stall         (out_stall),
        .o_match_count   (o_match_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (rst_n && o_valid && !out_stall) begin
            sb.check_count(o_match_count);
        end
        if (!rst_n || (in_valid && !o_stall) || (o_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("keyword_word_match_counter: mismatch");
            $finish;
        end
    end

    // output side: per-result stall, plus one long hold-off on request
    initial begin : receiver
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever begin
            gap = receiver_calm ? 0 : $urandom_range(0, 14);
            if (hold_request) begin
                hold_request = 1'b0;
                gap += HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!o_valid) @(posedge clk);
        end
    end

    task automatic drive_item(input logic [CHAR_W-1:0] c, input logic is_last);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_eor   <= is_last;
        @(posedge clk);
        while (o_stall) @(posedge clk);
        sb.note_transfer(c, is_last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            drive_item(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_bytes.size(); i++) begin
            drive_item(rec_bytes[i], i == rec_bytes.size() - 1);
        end
        phase_items  += rec_bytes.size();
        random_items += rec_bytes.size();
    endtask

    // wait for all counts, then let the pipeline empty before reconfiguring
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_counts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.write_register(idx, d);
    endtask

    task automatic load_keyword(input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] hi,
                                input logic [LEN_W-1:0]      len);
        logic [CFG_DATA_W-1:0] len_word;
        len_word            = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        cfg_write(REG_KEY_LOW, lo);
        cfg_write(REG_KEY_HIGH, hi);
        cfg_write(REG_KEY_LEN, len_word);
        cfg_write(REG_NONE, {$urandom, $urandom});
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [CHAR_W-1:0] vary_case(input logic [CHAR_W-1:0] c);
        if ((c | CASE_BIT) >= LOW_A && (c | CASE_BIT) <= LOW_Z && $urandom_range(0, 1)) begin
            return c ^ CASE_BIT;
        end
        return c;
    endfunction

    task automatic pick_keyword(input int p);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [LEN_W-1:0]      len;
        logic [CHAR_W-1:0]     ch;
        int unsigned           alphabet;
        case (p)
            0:       len = 5'd16;
            1:       len = 5'd0;
            2:       len = 5'd31;
            3:       len = 5'd1;
            default: len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(1, 5));
        endcase
        alphabet = (p == 2) ? 3 : (p == 3) ? 4 : $urandom_range(0, 2);
        for (int k = 0; k < KEY_CHARS; k++) begin
            case (alphabet)
                0:       ch = LOW_A + 8'($urandom_range(0, 1));
                1:       ch = vary_case(LOW_A + 8'($urandom_range(0, 25)));
                2:       ch = 8'($urandom_range(0, 255));
                3:       ch = 8'hFF;
                default: ch = 8'h00;
            endcase
            if (k < 8) begin
                lo[8*k +: 8] = ch;
            end else begin
                hi[8*(k-8) +: 8] = ch;
            end
        end
        load_keyword(lo, hi, len);
    endtask

    // record = tokens: occurrences with assorted neighbours, near misses, words, noise
    task automatic build_record();
        int unsigned       len;
        int unsigned       kind;
        logic [CHAR_W-1:0] ch;
        rec_bytes.delete();
        len = sb.eff_len();
        repeat ($urandom_range(1, 5)) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                case ($urandom_range(0, 5))
                    0:       rec_bytes.push_back(8'($urandom_range(0, 255)));
                    1:       ;
                    default: rec_bytes.push_back(CHAR_SPACE);
                endcase
                for (int k = 0; k < len; k++) begin
                    rec_bytes.push_back(vary_case(sb.key_char(k)));
                end
                case ($urandom_range(0, 6))
                    0:       rec_bytes.push_back(CHAR_SPACE);
                    1:       rec_bytes.push_back(CHAR_COMMA);
                    2:       rec_bytes.push_back(CHAR_PERIOD);
                    3:       rec_bytes.push_back(CHAR_LOW_S);
                    4:       rec_bytes.push_back(CHAR_LOW_S ^ CASE_BIT);
                    5:       rec_bytes.push_back(8'($urandom_range(0, 255)));
                    default: ;
                endcase
            end else if (kind < 15) begin
                rec_bytes.push_back(CHAR_SPACE);
                for (int k = 0; k + 1 < len; k++) begin
                    rec_bytes.push_back(vary_case(sb.key_char(k)));
                end
                rec_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 18) begin
                repeat ($urandom_range(1, 8)) begin
                    ch = $urandom_range(0, 1) ? sb.key_char($urandom_range(0, len - 1))
                                              : LOW_A + 8'($urandom_range(0, 25));
                    rec_bytes.push_back(vary_case(ch));
                end
                rec_bytes.push_back(CHAR_SPACE);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    rec_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        if (rec_bytes.size() == 0) begin
            rec_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: keyword held in upper case, text in mixed case
        load_keyword(64'h0000_0000_4452_4F57, 64'h0, 5'd4);
        send_text("word ");
        send_text(" WoRd.");
        send_text(" word");
        send_text(" words");
        drive_item(8'h00, 1'b0);
        drive_item(8'hFF, 1'b1);
        settle();

        for (int p = 0; random_items < RANDOM_ITEMS || sb.records < MIN_RECORDS; p++) begin
            sender_calm   = (p % 5 == 4) || (p == 5);
            receiver_calm = (p % 5 == 4);
            hold_request  = (p == 5);
            pick_keyword(p);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                build_record();
                send_record();
            end
            settle();
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d characters in %0d records under %0d keyword settings;",
                 sb.chars, sb.records, settings);
        $display("%0d whole-word matches predicted across all records.", sb.found);
        if (sb.errors == 0 && sb.expected_counts.size() == 0) begin
            $display("keyword_word_match_counter: match");
        end else begin
            $display("keyword_word_match_counter: mismatch");
        end
        $finish;
    end

endmodule
